### sv/data_run_list_decoder_defines.svh
// Assertion macros used by the decoder step module.
`ifndef DATA_RUN_LIST_DECODER_DEFINES_SVH
`define DATA_RUN_LIST_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/drld_pkg.sv
`timescale 1ns / 1ps

package drld_pkg;

	localparam int unsigned FIELD_W = 64;

	typedef struct packed {
		logic [FIELD_W-1:0] run_start;
		logic [FIELD_W-1:0] run_clusters;
		logic               end_marker;
		logic               list_done;
		logic               truncated;
	} result_t;

endpackage

### sv/drld_step.sv
`timescale 1ns / 1ps
`include "data_run_list_decoder_defines.svh"

module drld_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	output logic              res_valid,
	output drld_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_OFFSET,
		PH_SKIP
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  lsize_q, lsize_d;
	logic [3:0]  osize_q, osize_d;
	logic [3:0]  pos_q, pos_d;
	logic [63:0] lg_q, lg_d;
	logic [63:0] og_q, og_d;
	logic [63:0] base_q, base_d;

	logic [3:0]  pos_inc;
	logic [63:0] lg_gath;
	logic [63:0] og_gath;
	logic        off_done;
	logic [63:0] off_sel;
	logic [63:0] off_sum;

	function automatic logic [63:0] gather(input logic [63:0] acc, input logic [3:0] pos,
		input logic [7:0] b);
		logic [63:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (pos == 4'(i)) begin
				r[i*8 +: 8] = acc[i*8 +: 8] | b;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] nbytes);
		logic [63:0] r;
		case (nbytes)
			4'd1: r = {{56{v[7]}}, v[7:0]};
			4'd2: r = {{48{v[15]}}, v[15:0]};
			4'd3: r = {{40{v[23]}}, v[23:0]};
			4'd4: r = {{32{v[31]}}, v[31:0]};
			4'd5: r = {{24{v[39]}}, v[39:0]};
			4'd6: r = {{16{v[47]}}, v[47:0]};
			4'd7: r = {{8{v[55]}}, v[55:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	assign pos_inc  = pos_q + 4'd1;
	assign lg_gath  = gather(lg_q, pos_q, data_byte);
	assign og_gath  = gather(og_q, pos_q, data_byte);
	assign off_done = (pos_inc >= osize_q);
	assign off_sel  = off_done ? sext(og_gath, osize_q) : og_gath;
	assign off_sum  = base_q + off_sel;

	always_comb begin
		phase_d   = phase_q;
		lsize_d   = lsize_q;
		osize_d   = osize_q;
		pos_d     = pos_q;
		lg_d      = lg_q;
		og_d      = og_q;
		base_d    = base_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_HEADER: begin
				if (data_byte[3:0] == 4'd0) begin
					res_valid      = 1'b1;
					res.end_marker = 1'b1;
					res.list_done  = 1'b1;
					if (!final_byte) begin
						phase_d = PH_SKIP;
					end
				end else begin
					lsize_d = data_byte[3:0];
					osize_d = data_byte[7:4];
					phase_d = PH_LENGTH;
					if (final_byte) begin
						res_valid     = 1'b1;
						res.run_start = base_q;
						res.list_done = 1'b1;
						res.truncated = 1'b1;
					end
				end
			end
			PH_LENGTH: begin
				lg_d  = lg_gath;
				pos_d = pos_inc;
				if (pos_inc >= lsize_q) begin
					pos_d = 4'd0;
					if (osize_q == 4'd0) begin
						res_valid        = 1'b1;
						res.run_start    = base_q;
						res.run_clusters = lg_gath;
						res.list_done    = final_byte;
						phase_d          = PH_HEADER;
						lg_d             = '0;
					end else begin
						phase_d = PH_OFFSET;
						if (final_byte) begin
							res_valid        = 1'b1;
							res.run_start    = base_q;
							res.run_clusters = lg_gath;
							res.list_done    = 1'b1;
							res.truncated    = 1'b1;
						end
					end
				end else if (final_byte) begin
					res_valid        = 1'b1;
					res.run_start    = base_q;
					res.run_clusters = lg_gath;
					res.list_done    = 1'b1;
					res.truncated    = 1'b1;
				end
			end
			PH_OFFSET: begin
				og_d  = og_gath;
				pos_d = pos_inc;
				if (off_done) begin
					res_valid        = 1'b1;
					res.run_start    = off_sum;
					res.run_clusters = lg_q;
					res.list_done    = final_byte;
					phase_d          = PH_HEADER;
					pos_d            = 4'd0;
					lg_d             = '0;
					og_d             = '0;
					base_d           = off_sum;
				end else if (final_byte) begin
					res_valid        = 1'b1;
					res.run_start    = off_sum;
					res.run_clusters = lg_q;
					res.list_done    = 1'b1;
					res.truncated    = 1'b1;
				end
			end
			PH_SKIP: begin
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase

		if (final_byte) begin
			phase_d = PH_HEADER;
			lsize_d = 4'd0;
			osize_d = 4'd0;
			pos_d   = 4'd0;
			lg_d    = '0;
			og_d    = '0;
			base_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			lsize_q <= 4'd0;
			osize_q <= 4'd0;
			pos_q   <= 4'd0;
			lg_q    <= '0;
			og_q    <= '0;
			base_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			lsize_q <= lsize_d;
			osize_q <= osize_d;
			pos_q   <= pos_d;
			lg_q    <= lg_d;
			og_q    <= og_d;
			base_q  <= base_d;
		end
	end

	`DRLD_ASSERT_IMP(a_end_clean, clk, arst_n, fire && res_valid && res.end_marker,
		res.run_start == '0 && res.run_clusters == '0 && !res.truncated && res.list_done,
		"End marker word carries run data")
	`DRLD_ASSERT_IMP(a_trunc_final, clk, arst_n, fire && res_valid && res.truncated,
		final_byte && res.list_done, "Truncated word without final byte")
	`DRLD_ASSERT_IMP(a_idle_clear, clk, arst_n, phase_q == PH_HEADER || phase_q == PH_SKIP,
		lg_q == '0 && og_q == '0 && pos_q == 4'd0, "Gather state not cleared between runs")
	`DRLD_ASSERT_NEXT(a_list_reset, clk, arst_n, fire && final_byte,
		base_q == '0 && phase_q == PH_HEADER, "Running start cluster not cleared after list")

endmodule

### sv/drld_out.sv
`timescale 1ns / 1ps

module drld_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  drld_pkg::result_t res,
	input  logic              fire,
	input  logic              out_stall,
	output logic              adv,
	output logic              out_valid,
	output drld_pkg::result_t out_res
);

	logic              valid_q;
	drld_pkg::result_t res_q;

	assign adv       = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fire && res_valid) begin
			res_q <= res;
		end
	end

endmodule

### sv/data_run_list_decoder.sv
// Mapping-pair list decoder: one input word per cycle, at most one result word per input.
// Path: an input word is registered in the input stage, and its result word in the output register, which presents it.
// Throughput: one input word per cycle; only a held result word stalls the input.
// Reset: arst_n clears the run state and the valid flags of the input and output registers.
`timescale 1ns / 1ps

module data_run_list_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               final_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] run_start,
	output logic [63:0]        run_clusters,
	output logic               end_marker,
	output logic               list_done,
	output logic               truncated
);

	logic              valid_s1;
	logic [7:0]        data_byte_s1;
	logic              final_byte_s1;
	logic              adv;
	logic              fire;
	logic              res_valid;
	drld_pkg::result_t res;
	drld_pkg::result_t out_res;

	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_byte_s1  <= data_byte;
			final_byte_s1 <= final_byte;
		end
	end

	drld_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_byte  (data_byte_s1),
		.final_byte (final_byte_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	drld_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.fire      (fire),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign run_start    = $signed(out_res.run_start);
	assign run_clusters = out_res.run_clusters;
	assign end_marker   = out_res.end_marker;
	assign list_done    = out_res.list_done;
	assign truncated    = out_res.truncated;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT = 400000;
	localparam int ITEMS = 1100;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE = 10;

	typedef enum logic [1:0] {S_HEAD, S_LEN, S_OFF, S_IGNORE} dec_state_t;

	typedef struct {
		logic [7:0]        b;
		logic              fin;
		bit                typed;
		bit                yields;
		drld_pkg::result_t res;
	} row_t;

	localparam drld_pkg::result_t NO_RES = '0;
	localparam drld_pkg::result_t END_RES = '{64'd0, 64'd0, 1'b1, 1'b1, 1'b0};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = 8'h00;
	logic               final_byte = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [63:0] run_start;
	logic [63:0]        run_clusters;
	logic               end_marker;
	logic               list_done;
	logic               truncated;

	dec_state_t  st = S_HEAD;
	logic [3:0]  len_bytes = '0;
	logic [3:0]  off_bytes = '0;
	logic [3:0]  byte_idx = '0;
	logic [63:0] len_acc = '0;
	logic [63:0] off_acc = '0;
	logic [63:0] base_lcn = '0;

	drld_pkg::result_t runs_due [$];
	drld_pkg::result_t head_run;
	int      errors = 0;
	int      cycles = 0;
	int      n_items = 0;
	int      n_results = 0;
	int      n_runs = 0;
	int      n_ends = 0;
	int      n_cut = 0;
	bit      calm = 1'b0;
	bit      rx_hold = 1'b0;

	row_t dir_rows [23] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, END_RES},
		'{8'hAB, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h5F, 1'b1, 1'b1, 1'b0, NO_RES},
		'{8'h11, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b1, 1'b1, '{64'hFFFF_FFFF_FFFF_FF80, 64'hFF, 1'b0, 1'b1, 1'b0}},
		'{8'h01, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h7F, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h09, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h12, 1'b0, 1'b1, 1'b1, '{64'd0, {64{1'b1}}, 1'b0, 1'b0, 1'b0}},
		'{8'h21, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h05, 1'b1, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b1, 1'b1, END_RES},
		'{8'h31, 1'b1, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b0, 1'b1, 1'b1}},
		'{8'hF0, 1'b1, 1'b1, 1'b1, END_RES}
	};

	data_run_list_decoder i_dut (.*);

	always #10 clk = ~clk;

	function automatic void clear_list_state();
		st = S_HEAD;
		len_bytes = '0;
		off_bytes = '0;
		byte_idx = '0;
		len_acc = '0;
		off_acc = '0;
		base_lcn = '0;
	endfunction

	function automatic void queue_run(input drld_pkg::result_t r);
		runs_due.insert(runs_due.size(), r);
	endfunction

	function automatic logic [63:0] sext_offset(logic [63:0] v, logic [3:0] n);
		logic [63:0] mask;
		if (n == 4'd0 || n >= 4'd8)
			return v;
		mask = (64'd1 << (n * 8)) - 64'd1;
		v &= mask;
		if (v[n * 8 - 1])
			v |= ~mask;
		return v;
	endfunction

	function automatic drld_pkg::result_t close_run(input bit complete, input bit fin);
		drld_pkg::result_t r;
		base_lcn += complete ? sext_offset(off_acc, off_bytes) : off_acc;
		r.run_start = base_lcn;
		r.run_clusters = len_acc;
		r.end_marker = 1'b0;
		r.list_done = fin;
		r.truncated = !complete;
		if (fin) begin
			clear_list_state();
		end else begin
			st = S_HEAD;
			byte_idx = '0;
			len_acc = '0;
			off_acc = '0;
		end
		return r;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic fin,
			output drld_pkg::result_t r);
		r = '0;
		case (st)
		S_HEAD: begin
			if (b[3:0] == 4'd0) begin
				if (fin)
					clear_list_state();
				else
					st = S_IGNORE;
				r = END_RES;
				return 1'b1;
			end
			len_bytes = b[3:0];
			off_bytes = b[7:4];
			byte_idx = '0;
			len_acc = '0;
			off_acc = '0;
			st = S_LEN;
			if (fin) begin
				r = close_run(1'b0, 1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		S_LEN: begin
			if (byte_idx < 4'd8)
				len_acc |= 64'(b) << (byte_idx * 8);
			byte_idx = byte_idx + 4'd1;
			if (byte_idx >= len_bytes) begin
				byte_idx = '0;
				if (off_bytes == 4'd0) begin
					r = close_run(1'b1, fin);
					return 1'b1;
				end
				st = S_OFF;
			end
			if (fin) begin
				r = close_run(1'b0, 1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		S_OFF: begin
			if (byte_idx < 4'd8)
				off_acc |= 64'(b) << (byte_idx * 8);
			byte_idx = byte_idx + 4'd1;
			if (byte_idx >= off_bytes) begin
				r = close_run(1'b1, fin);
				return 1'b1;
			end
			if (fin) begin
				r = close_run(1'b0, 1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		default: begin
			if (fin)
				clear_list_state();
			return 1'b0;
		end
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic fin, input bit idle_ok,
			input bit typed, input bit yields, input drld_pkg::result_t want);
		drld_pkg::result_t got;
		bit                has;
		data_byte <= b;
		final_byte <= fin;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_items++;
		has = decode_byte(b, fin, got);
		if (typed) begin
			if (yields)
				queue_run(want);
		end else if (has) begin
			queue_run(got);
		end
		if (idle_ok && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic drain_runs();
		in_valid <= 1'b0;
		do @(posedge clk); while (runs_due.size() != 0);
	endtask

	task automatic send_list();
		logic [7:0] seq [$];
		int         kind;
		int         ls;
		int         os;
		int         cut;
		bit         idle_ok;
		kind = $urandom_range(0, 19);
		idle_ok = $urandom_range(0, 3) != 0;
		if (kind < 2) begin
			repeat ($urandom_range(1, 12)) seq.insert(seq.size(), 8'($urandom));
		end else begin
			repeat ($urandom_range(0, 6)) begin
				ls = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
				os = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
				seq.insert(seq.size(), {4'(os), 4'(ls)});
				repeat (ls + os) seq.insert(seq.size(), 8'($urandom));
			end
			if (kind < 16 || seq.size() == 0) begin
				seq.insert(seq.size(), {4'($urandom_range(0, 15)), 4'h0});
				repeat ($urandom_range(0, 3)) seq.insert(seq.size(), 8'($urandom));
			end else if (kind < 19 && seq.size() > 1) begin
				cut = $urandom_range(1, seq.size() - 1);
				seq = seq[0:cut-1];
			end
		end
		foreach (seq[i])
			put_byte(seq[i], i == seq.size() - 1, idle_ok, 1'b0, 1'b0, NO_RES);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("data_run_list_decoder: mismatch");
			$finish;
		end
	end

	initial begin
		forever begin
			if (rx_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				out_stall <= 1'b0;
				repeat (calm ? 1 : $urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (runs_due.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				head_run = runs_due.pop_front();
				if (head_run.end_marker)
					n_ends++;
				else
					n_runs++;
				if (head_run.truncated)
					n_cut++;
				if (run_start !== head_run.run_start) begin
					$error("run_start: expected %h, got %h", head_run.run_start, run_start);
					errors++;
				end
				if (run_clusters !== head_run.run_clusters) begin
					$error("run_clusters: expected %h, got %h", head_run.run_clusters,
						run_clusters);
					errors++;
				end
				if (end_marker !== head_run.end_marker) begin
					$error("end_marker: expected %b, got %b", head_run.end_marker, end_marker);
					errors++;
				end
				if (list_done !== head_run.list_done) begin
					$error("list_done: expected %b, got %b", head_run.list_done, list_done);
					errors++;
				end
				if (truncated !== head_run.truncated) begin
					$error("truncated: expected %b, got %b", head_run.truncated, truncated);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			put_byte(dir_rows[i].b, dir_rows[i].fin, 1'b1, dir_rows[i].typed,
				dir_rows[i].yields, dir_rows[i].res);
		drain_runs();

		// Hold the output back while lists keep arriving, so that the input backs up.
		rx_hold = 1'b1;
		calm = 1'b1;
		while (rx_hold)
			send_list();
		calm = 1'b0;
		drain_runs();

		while (n_items < ITEMS) begin
			if (n_items >= ITEMS - 150)
				calm = 1'b1;
			send_list();
			if ($urandom_range(0, 14) == 0)
				drain_runs();
		end

		drain_runs();
		repeat (SETTLE) @(posedge clk);

		$display("Decoded %0d list words into %0d result words over %0d cycles.",
			n_items, n_results, cycles);
		$display("Results: %0d runs (%0d cut short) and %0d end markers.",
			n_runs, n_cut, n_ends);
		if (errors == 0) begin
			$display("data_run_list_decoder: match");
		end else begin
			$display("data_run_list_decoder: mismatch");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/drld_pkg.sv
sv/drld_step.sv
sv/drld_out.sv
sv/data_run_list_decoder.sv
bench/tb.sv
